/* rtl/pket_pkg.sv */
// Package for the per-key event throttle: shared widths, reset values and
// the result type of the key/time compare unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pket_pkg;

   // Time stamp and interval widths are fixed by the word format
   localparam int TIME_WIDTH         = 32;
   localparam int INTERVAL_WIDTH     = 16;
   localparam int SLOT_FIELD_WIDTH   = 4;
   localparam logic [INTERVAL_WIDTH-1:0] MIN_INTERVAL_RESET = 16'd30;

   // Outcome of comparing one stored slot against the current event
   typedef struct packed {
      logic match;     // stored key equals the event key
      logic too_soon;  // signed (now - stored time) is below the interval
   } cmp_result_type;

endpackage : pket_pkg

`default_nettype wire

/* rtl/per_key_event_throttle.sv */
// Top level of the per-key event throttle: scan sequencer, slot table RAM,
// compare unit and result register. Uses pket_pkg, pket_ram and pket_cmp.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted word carries an event key and the current time in seconds and
// yields one result word: allow, hit, slot and recorded. Known keys sit in a
// table of NUM_SLOTS slots held in one RAM with a registered read port; a
// sequencer walks the filled slots in order, one slot per cycle through a
// single key/time compare unit, and stops at the first match. A miss walks
// every filled slot before its result is posted. The result sits in an output
// register, so a new word is taken while a finished result waits; the scan
// only stalls at its final step if that register is still occupied.
// min_interval is written through csr_wr_en / csr_wr_data and resets to 30.
// Reset empties the table by clearing the fill count; no clearing pass runs.

module per_key_event_throttle #(
   parameter int NUM_SLOTS = 16,
   parameter int KEY_WIDTH = 32
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // configuration
   input  wire logic                                  csr_wr_en,
   input  wire logic [pket_pkg::INTERVAL_WIDTH-1:0]   csr_wr_data,
   // event words
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [31:0]                           req_event_key,
   input  wire logic [pket_pkg::TIME_WIDTH-1:0]       req_now_seconds,
   // result words
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_allow,
   output logic                                       rsp_hit,
   output logic [pket_pkg::SLOT_FIELD_WIDTH-1:0]      rsp_slot,
   output logic                                       rsp_recorded
);

   import pket_pkg::*;

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(NUM_SLOTS + 1);
   localparam int ENTRY_W = KEY_WIDTH + TIME_WIDTH;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           scan_ff, scan_in;
   logic [CNT_W-1:0]           used_ff, used_in;
   logic [INTERVAL_WIDTH-1:0]  interval_ff, interval_in;
   logic [KEY_WIDTH-1:0]       key_ff, key_in;
   logic [TIME_WIDTH-1:0]      now_ff, now_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_allow_ff, rsp_allow_in;
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [SLOT_FIELD_WIDTH-1:0] rsp_slot_ff, rsp_slot_in;
   logic                       rsp_recorded_ff, rsp_recorded_in;

   logic [KEY_WIDTH+31:0]      key_ext;
   logic                       accept;
   logic                       out_free;
   logic [CNT_W-1:0]           scan_next;
   logic [CNT_W+SLOT_FIELD_WIDTH-1:0] scan_slot_ext;
   logic [CNT_W+SLOT_FIELD_WIDTH-1:0] used_slot_ext;

   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [ENTRY_W-1:0]         ram_wr_data;
   logic [ENTRY_W-1:0]         ram_rd_data;
   cmp_result_type             cmp_res;

   // Keep the low KEY_WIDTH bits of the key, zero-extended when wider
   assign key_ext = {{KEY_WIDTH{1'b0}}, req_event_key};

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_next = scan_ff + 1'b1;

   assign scan_slot_ext = {{SLOT_FIELD_WIDTH{1'b0}}, scan_ff};
   assign used_slot_ext = {{SLOT_FIELD_WIDTH{1'b0}}, used_ff};

   // Slot table: key in the upper bits, last pass time in the lower bits
   pket_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_SLOTS)
   ) u_table (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (scan_in[IDX_W-1:0]),
      .rd_data_ff (ram_rd_data)
   );

   pket_cmp #(
      .KEY_WIDTH (KEY_WIDTH)
   ) u_cmp (
      .event_key    (key_ff),
      .now_seconds  (now_ff),
      .stored_key   (ram_rd_data[ENTRY_W-1:TIME_WIDTH]),
      .stored_time  (ram_rd_data[TIME_WIDTH-1:0]),
      .min_interval (interval_ff),
      .result       (cmp_res)
   );

   // Sequencer: scan filled slots, then post a result and update the table when the event is recorded
   always_comb begin
      state_in        = state_ff;
      scan_in         = scan_ff;
      used_in         = used_ff;
      interval_in     = csr_wr_en ? csr_wr_data : interval_ff;
      key_in          = key_ff;
      now_in          = now_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_allow_in    = rsp_allow_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_recorded_in = rsp_recorded_ff;
      ram_wr_en       = 1'b0;
      ram_wr_addr     = scan_ff[IDX_W-1:0];
      ram_wr_data     = {key_ff, now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in   = key_ext[KEY_WIDTH-1:0];
               now_in   = req_now_seconds;
               scan_in  = '0;
               state_in = (used_ff == '0) ? ST_MISS : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_res.match) begin
               // Hit: pass and refresh the time, or hold back
               if (out_free) begin
                  ram_wr_en       = !cmp_res.too_soon;
                  rsp_valid_in    = 1'b1;
                  rsp_allow_in    = !cmp_res.too_soon;
                  rsp_hit_in      = 1'b1;
                  rsp_slot_in     = scan_slot_ext[SLOT_FIELD_WIDTH-1:0];
                  rsp_recorded_in = !cmp_res.too_soon;
                  state_in        = ST_IDLE;
               end
            end else if (scan_next == used_ff) begin
               state_in = ST_MISS;
            end else begin
               scan_in = scan_next;
            end
         end
         ST_MISS: begin
            // Unknown key: take the next free slot if there is one
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_allow_in = 1'b1;
               rsp_hit_in   = 1'b0;
               state_in     = ST_IDLE;
               if (used_ff < NUM_SLOTS[CNT_W-1:0]) begin
                  ram_wr_en       = 1'b1;
                  ram_wr_addr     = used_ff[IDX_W-1:0];
                  used_in         = used_ff + 1'b1;
                  rsp_slot_in     = used_slot_ext[SLOT_FIELD_WIDTH-1:0];
                  rsp_recorded_in = 1'b1;
               end else begin
                  rsp_slot_in     = '0;
                  rsp_recorded_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state, counters, the held event and the result register
   always_ff @(posedge clock) begin
      scan_ff         <= scan_in;
      key_ff          <= key_in;
      now_ff          <= now_in;
      rsp_allow_ff    <= rsp_allow_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_recorded_ff <= rsp_recorded_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         interval_ff  <= MIN_INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_allow    = rsp_allow_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_slot     = rsp_slot_ff;
   assign rsp_recorded = rsp_recorded_ff;

endmodule : per_key_event_throttle

`default_nettype wire

/* rtl/pket_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the slot table of the per-key event throttle; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pket_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry, both on the rising edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule : pket_ram

`default_nettype wire

/* rtl/pket_cmp.sv */
// Shared compare unit: matches one stored key against the event key and
// checks the elapsed time against the minimum interval. Uses pket_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pket_cmp #(
   parameter int KEY_WIDTH = 32
) (
   input  wire logic [KEY_WIDTH-1:0]                   event_key,
   input  wire logic [pket_pkg::TIME_WIDTH-1:0]        now_seconds,
   input  wire logic [KEY_WIDTH-1:0]                   stored_key,
   input  wire logic [pket_pkg::TIME_WIDTH-1:0]        stored_time,
   input  wire logic [pket_pkg::INTERVAL_WIDTH-1:0]    min_interval,
   output pket_pkg::cmp_result_type                    result
);

   import pket_pkg::*;

   logic [TIME_WIDTH-1:0] elapsed;
   logic [TIME_WIDTH-1:0] interval_ext;

   // Elapsed time wraps modulo 2^32; the top bit marks a negative difference
   assign elapsed      = now_seconds - stored_time;
   assign interval_ext = {{(TIME_WIDTH-INTERVAL_WIDTH){1'b0}}, min_interval};

   always_comb begin
      result.match    = (stored_key == event_key);
      result.too_soon = elapsed[TIME_WIDTH-1] || (elapsed < interval_ext);
   end

endmodule : pket_cmp

`default_nettype wire
